// ===== rtl/dimmer_wave_envelope_sampler_macros.svh =====
// assertion macros for the dimmer wave envelope sampler
// used by the top level only, no other dependencies
`ifndef DIMMER_WAVE_ENVELOPE_SAMPLER_MACROS_SVH
`define DIMMER_WAVE_ENVELOPE_SAMPLER_MACROS_SVH

// same-cycle implication
`define DWES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dwes_pkg.sv =====
// package for the dimmer wave envelope sampler: constants, config struct,
// register indexes and the raised cosine table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dwes_pkg;

	localparam int FRAC_W     = 16;
	localparam int ONE_W      = FRAC_W + 1;
	localparam logic [ONE_W-1:0] ONE_Q = ONE_W'(1) << FRAC_W;

	localparam int DEG_FULL   = 360;
	localparam int PCT_FULL   = 100;
	localparam int P100_W     = FRAC_W + 7;

	// floor(off * 2^16 / 360) as (off * OFF_RECIP) >> OFF_SHIFT, exact for off below 360
	localparam logic [23:0] OFF_RECIP = 24'd11930465;
	localparam int OFF_SHIFT  = 16;
	localparam int OFF_PROD_W = 33;

	localparam int COS_DEPTH  = 256;
	localparam int COS_LOG    = $clog2(COS_DEPTH);
	localparam int COS_IDX_W  = COS_LOG + 1;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int DIV_NUM_W  = 48;
	localparam int DIV_DEN_W  = 24;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;
	localparam int TAG_W      = P100_W + 1;

	localparam int T_W        = ONE_W + 8;
	localparam int U_W        = T_W + 16;
	localparam int Y_W        = 24;
	localparam logic [U_W-1:0] LEVEL_HALF = U_W'((255 << FRAC_W) >> 1);
	localparam logic [15:0] DIV255_MUL = 16'd32897;
	localparam int DIV255_SHIFT = 23;

	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [1:0] SHAPE_COS    = 2'd0;
	localparam logic [1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [1:0] SHAPE_LINEAR = 2'd2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CYCLE,
		REG_START,
		REG_WIDTH,
		REG_FADE_IN,
		REG_FADE_OUT,
		REG_SHAPE,
		REG_LEVEL
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] cycle_ms;
		logic [8:0]  start_offset_deg;
		logic [8:0]  wave_width_deg;
		logic [6:0]  fade_in_pct;
		logic [6:0]  fade_out_pct;
		logic [1:0]  wave_shape;
		logic [7:0]  wave_level;
	} cfg_t;

	typedef logic [ONE_W-1:0] cos_rom_t [COS_DEPTH+1];

	// sin^2 table built from a truncated taylor series in q30
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int i = 0; i <= COS_DEPTH; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / 64'(COS_DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int k = 1; k <= 10; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k & 1) == 1) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > (64'd1 << 30)) begin
				sum = 64'd1 << 30;
			end
			v = (sum * sum + (64'd1 << (59 - FRAC_W))) >> (60 - FRAC_W);
			if (v > 64'(ONE_Q)) begin
				v = 64'(ONE_Q);
			end
			rom[i] = ONE_W'(v);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

// ===== rtl/dwes_if.sv =====
// valid/ready channel interfaces for sample beats and level beats
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dwes_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] elapsed_ms;
	logic [31:0] time_offset_ms;
	logic [8:0]  head_offset_deg;

	modport source (output valid, output elapsed_ms, output time_offset_ms,
		output head_offset_deg, input ready);
	modport sink (input valid, input elapsed_ms, input time_offset_ms,
		input head_offset_deg, output ready);
endinterface

interface dwes_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] dimmer_level;

	modport source (output valid, output dimmer_level, input ready);
	modport sink (input valid, input dimmer_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/dwes_cfg.sv =====
// apb register file for the envelope settings
// depends on dwes_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwes_cfg
	import dwes_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_ms         <= 24'd1000;
			cfg_q.start_offset_deg <= 9'd0;
			cfg_q.wave_width_deg   <= 9'd360;
			cfg_q.fade_in_pct      <= 7'd0;
			cfg_q.fade_out_pct     <= 7'd0;
			cfg_q.wave_shape       <= SHAPE_COS;
			cfg_q.wave_level       <= 8'd255;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_CYCLE:    cfg_q.cycle_ms         <= pwdata[23:0];
				REG_START:    cfg_q.start_offset_deg <= pwdata[8:0];
				REG_WIDTH:    cfg_q.wave_width_deg   <= pwdata[8:0];
				REG_FADE_IN:  cfg_q.fade_in_pct      <= pwdata[6:0];
				REG_FADE_OUT: cfg_q.fade_out_pct     <= pwdata[6:0];
				REG_SHAPE:    cfg_q.wave_shape       <= pwdata[1:0];
				REG_LEVEL:    cfg_q.wave_level       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CYCLE:    prdata = 32'(cfg_q.cycle_ms);
			REG_START:    prdata = 32'(cfg_q.start_offset_deg);
			REG_WIDTH:    prdata = 32'(cfg_q.wave_width_deg);
			REG_FADE_IN:  prdata = 32'(cfg_q.fade_in_pct);
			REG_FADE_OUT: prdata = 32'(cfg_q.fade_out_pct);
			REG_SHAPE:    prdata = 32'(cfg_q.wave_shape);
			REG_LEVEL:    prdata = 32'(cfg_q.wave_level);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dwes_div.sv =====
// pipelined restoring divider, four quotient bits per stage, with a tag
// carried alongside; divisor held steady while beats are in flight; uses dwes_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwes_div
	import dwes_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_vld,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0]     tag_in,
	output logic                      out_vld,
	output logic      [DIV_NUM_W-1:0] quo,
	output logic      [TAG_W-1:0]     tag_out
);

	logic                 vld_s [DIV_STAGES];
	logic [DIV_DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_NUM_W-1:0] nq_s  [DIV_STAGES];
	logic [TAG_W-1:0]     tag_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic                 vld_in;
		logic [DIV_DEN_W-1:0] rem_in;
		logic [DIV_NUM_W-1:0] nq_in;
		logic [TAG_W-1:0]     tag_i;
		logic [DIV_DEN_W-1:0] rem_nx;
		logic [DIV_NUM_W-1:0] nq_nx;

		if (j == 0) begin : g_head
			assign vld_in = in_vld;
			assign rem_in = '0;
			assign nq_in  = num;
			assign tag_i  = tag_in;
		end else begin : g_body
			assign vld_in = vld_s[j-1];
			assign rem_in = rem_s[j-1];
			assign nq_in  = nq_s[j-1];
			assign tag_i  = tag_s[j-1];
		end

		always_comb begin
			logic [DIV_DEN_W:0] trial;
			rem_nx = rem_in;
			nq_nx  = nq_in;
			trial  = '0;
			for (int b = 0; b < DIV_STEP; b++) begin
				trial = {rem_nx, nq_nx[DIV_NUM_W-1]};
				nq_nx = {nq_nx[DIV_NUM_W-2:0], 1'b0};
				if (trial >= {1'b0, den}) begin
					trial    = trial - {1'b0, den};
					nq_nx[0] = 1'b1;
				end
				rem_nx = trial[DIV_DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= rem_nx;
				nq_s[j]  <= nq_nx;
				tag_s[j] <= tag_i;
			end
		end
	end

	assign out_vld = vld_s[DIV_STAGES-1];
	assign quo     = nq_s[DIV_STAGES-1];
	assign tag_out = tag_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/dwes_ramp.sv =====
// ramp shaping and level scaling: cosine table lookup, interpolation,
// level multiply and rounding divide by 255; uses dwes_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwes_ramp
	import dwes_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_vld,
	input  wire logic             ramp,
	input  wire logic [ONE_W-1:0] x,
	input  wire logic             zero,
	input  wire cfg_t             cfg,
	output logic                  out_vld,
	output logic      [15:0]      level
);

	logic [COS_IDX_W-1:0] idx;
	logic [COS_IDX_W-1:0] idx_c;
	logic [COS_IDX_W-1:0] idx_n;
	logic [FRAC_W-1:0]    rem;
	logic                 use_tab;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [ONE_W-1:0]     a_s1, b_s1, lin_s1;
	logic [FRAC_W-1:0]    rem_s1;
	logic                 tab_s1;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic [ONE_W-1:0]     v_s2;
	logic [T_W-1:0]       t_s3;
	logic [Y_W-1:0]       y_s4, y_s5;
	logic [ONE_W-1:0]     q0_s5;
	logic [15:0]          level_s6;

	logic signed [ONE_W:0]      diff;
	logic signed [2*ONE_W:0]    prod;
	logic signed [2*ONE_W+1:0]  interp;
	logic [ONE_W-1:0]           v_nx;
	logic [U_W-1:0]             u;
	logic [Y_W+16-1:0]          yp;
	logic [Y_W+1:0]             q255;
	logic [ONE_W-1:0]           q;

	assign idx     = x[FRAC_W:FRAC_W-COS_LOG];
	assign idx_c   = (idx >= COS_IDX_W'(COS_DEPTH)) ? COS_IDX_W'(COS_DEPTH) : idx;
	assign idx_n   = (idx_c == COS_IDX_W'(COS_DEPTH)) ? idx_c : idx_c + 1'b1;
	assign rem     = {x[FRAC_W-COS_LOG-1:0], COS_LOG'(0)};
	assign use_tab = ramp && (cfg.wave_shape == SHAPE_COS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// table lookup or straight value
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= COS_ROM[idx_c];
			b_s1    <= COS_ROM[idx_n];
			rem_s1  <= rem;
			tab_s1  <= use_tab;
			lin_s1  <= ramp ? x : ONE_Q;
			zero_s1 <= zero;
		end
	end

	// linear interpolation between neighbouring entries, floor
	always_comb begin
		diff   = $signed({1'b0, b_s1}) - $signed({1'b0, a_s1});
		prod   = diff * $signed({2'b0, rem_s1});
		interp = $signed({(ONE_W+1)'(0), a_s1}) + (prod >>> FRAC_W);
		v_nx   = tab_s1 ? interp[ONE_W-1:0] : lin_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2    <= v_nx;
			zero_s2 <= zero_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3    <= T_W'(v_s2) * T_W'(cfg.wave_level);
			zero_s3 <= zero_s2;
		end
	end

	// times 65535 plus half, then drop the fraction
	assign u = (U_W'(t_s3) << 16) - U_W'(t_s3) + LEVEL_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s4    <= u[Y_W+16-1:16];
			zero_s4 <= zero_s3;
		end
	end

	// reciprocal of 255, at most one too high
	assign yp = (Y_W+16)'(y_s4) * (Y_W+16)'(DIV255_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s5   <= yp[DIV255_SHIFT+ONE_W-1:DIV255_SHIFT];
			y_s5    <= y_s4;
			zero_s5 <= zero_s4;
		end
	end

	always_comb begin
		q255 = ((Y_W+2)'(q0_s5) << 8) - (Y_W+2)'(q0_s5);
		q    = (q255 > (Y_W+2)'(y_s5)) ? q0_s5 - 1'b1 : q0_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s5) begin
				level_s6 <= '0;
			end else if (q[ONE_W-1]) begin
				level_s6 <= 16'hffff;
			end else begin
				level_s6 <= q[15:0];
			end
		end
	end

	assign out_vld = vld_s6;
	assign level   = level_s6;

endmodule

`default_nettype wire

// ===== rtl/dimmer_wave_envelope_sampler.sv =====
// top level of the dimmer wave envelope sampler: phase, window, fade zones
// depends on dwes_pkg, dwes_if, dwes_cfg, dwes_div, dwes_ramp and the macros header
`timescale 1ns / 1ps
`default_nettype none

`include "dimmer_wave_envelope_sampler_macros.svh"

// Takes one sample beat per clock unless stalled and returns one dimmer level
// beat per sample, in order. Beats pass three divider steps of 12 stages
// each (cycle position, window position and fade progress, the last done by two
// dividers side by side) plus twelve surrounding stages for phase, table lookup
// and level scaling. A stall on the output freezes the whole pipeline; the
// input is ready whenever the last stage is empty or being taken. Settings are
// written over the apb port and must only change while no sample is in flight.
module dimmer_wave_envelope_sampler
	import dwes_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dwes_in_if.sink                    in_ch,
	dwes_out_if.source                 out_ch,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	cfg_t cfg;
	logic adv;

	logic [6:0] fi_c, fo_c, sus_end;
	logic [7:0] fsum;

	logic [9:0]  hs;
	logic [8:0]  off;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [31:0] sum_s1;
	logic [8:0]  off_s1;

	logic [OFF_PROD_W-1:0] off_prod;

	logic                 vld_a, vld_d, vld_f;
	logic [DIV_NUM_W-1:0] qa, qd, qfi, qfo;
	logic [TAG_W-1:0]     tag_a, tag_d, tag_f;

	logic [FRAC_W:0]   ph_sum;
	logic [FRAC_W-1:0] phase_s2;
	logic [24:0]       m_s3, m_s4;
	logic              zero_s4, zero_s5, zero_s6;
	logic [P100_W-1:0] p100_s5;
	logic [P100_W-1:0] fo_num;

	logic [P100_W-1:0] p100;
	logic              ramp_nx;
	logic [ONE_W-1:0]  x_nx;
	logic [ONE_W-1:0]  prog;
	logic              ramp_s6;
	logic [ONE_W-1:0]  x_s6;

	logic              out_vld;
	logic [15:0]       out_level;

	dwes_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv         = !out_vld || out_ch.ready;
	assign in_ch.ready = adv;

	assign fi_c    = (cfg.fade_in_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL) : cfg.fade_in_pct;
	assign fo_c    = (cfg.fade_out_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL) : cfg.fade_out_pct;
	assign fsum    = 8'(fi_c) + 8'(fo_c);
	assign sus_end = (fsum >= 8'(PCT_FULL)) ? fi_c : 7'(PCT_FULL) - fo_c;

	// offsets mod 360
	always_comb begin
		hs = 10'(in_ch.head_offset_deg) + 10'(cfg.start_offset_deg);
		if (hs >= 10'(2 * DEG_FULL)) begin
			hs = hs - 10'(2 * DEG_FULL);
		end else if (hs >= 10'(DEG_FULL)) begin
			hs = hs - 10'(DEG_FULL);
		end
		off = hs[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_a;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_d;
			vld_s6 <= vld_f;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= in_ch.elapsed_ms + in_ch.time_offset_ms;
			off_s1 <= off;
		end
	end

	// offset fraction by reciprocal multiply, carried as the divider tag
	assign off_prod = OFF_PROD_W'(off_s1) * OFF_PROD_W'(OFF_RECIP);

	// low quotient bits give floor((pos mod cycle) * 2^16 / cycle)
	dwes_div u_div_cyc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.num     ({sum_s1, FRAC_W'(0)}),
		.den     (cfg.cycle_ms),
		.tag_in  (TAG_W'(off_prod[OFF_SHIFT+FRAC_W-1:OFF_SHIFT])),
		.out_vld (vld_a),
		.quo     (qa),
		.tag_out (tag_a)
	);

	assign ph_sum = {1'b0, qa[FRAC_W-1:0]} + {1'b0, tag_a[FRAC_W-1:0]};

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cfg.cycle_ms == '0) begin
				phase_s2 <= '0;
			end else begin
				phase_s2 <= ph_sum[FRAC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3 <= 25'(phase_s2) * 25'(DEG_FULL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s4    <= m_s3;
			zero_s4 <= (cfg.wave_width_deg == '0) ||
				(m_s3 >= {cfg.wave_width_deg, FRAC_W'(0)});
		end
	end

	dwes_div u_div_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s4),
		.num     (DIV_NUM_W'(m_s4)),
		.den     (DIV_DEN_W'(cfg.wave_width_deg)),
		.tag_in  ({zero_s4, P100_W'(0)}),
		.out_vld (vld_d),
		.quo     (qd),
		.tag_out (tag_d)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			p100_s5 <= P100_W'(qd[FRAC_W-1:0]) * P100_W'(PCT_FULL);
			zero_s5 <= tag_d[TAG_W-1];
		end
	end

	assign fo_num = p100_s5 - {sus_end, FRAC_W'(0)};

	dwes_div u_div_fin (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s5),
		.num     (DIV_NUM_W'(p100_s5)),
		.den     (DIV_DEN_W'(fi_c)),
		.tag_in  ({zero_s5, p100_s5}),
		.out_vld (vld_f),
		.quo     (qfi),
		.tag_out (tag_f)
	);

	dwes_div u_div_fout (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s5),
		.num     (DIV_NUM_W'(fo_num)),
		.den     (DIV_DEN_W'(fo_c)),
		.tag_in  ('0),
		.out_vld (),
		.quo     (qfo),
		.tag_out ()
	);

	// zone select
	always_comb begin
		p100    = tag_f[P100_W-1:0];
		ramp_nx = 1'b0;
		x_nx    = ONE_Q;
		prog    = (qfo > DIV_NUM_W'(ONE_Q)) ? ONE_Q : qfo[ONE_W-1:0];
		if (cfg.wave_shape == SHAPE_SQUARE) begin
			ramp_nx = 1'b0;
		end else if (fi_c != '0 && p100 < {fi_c, FRAC_W'(0)}) begin
			ramp_nx = 1'b1;
			x_nx    = {1'b0, qfi[FRAC_W-1:0]};
		end else if (p100 < {sus_end, FRAC_W'(0)}) begin
			ramp_nx = 1'b0;
		end else if (fo_c != '0) begin
			ramp_nx = 1'b1;
			x_nx    = ONE_Q - prog;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ramp_s6 <= ramp_nx;
			x_s6    <= x_nx;
			zero_s6 <= tag_f[TAG_W-1];
		end
	end

	dwes_ramp u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s6),
		.ramp    (ramp_s6),
		.x       (x_s6),
		.zero    (zero_s6),
		.cfg     (cfg),
		.out_vld (out_vld),
		.level   (out_level)
	);

	assign out_ch.valid        = out_vld;
	assign out_ch.dimmer_level = out_level;

	`DWES_ASSERT_NXT(a_accept_enters, clk, arst_n, in_ch.valid && in_ch.ready, vld_s1, "accepted beat lost at entry")
	`DWES_ASSERT_NXT(a_stall_holds, clk, arst_n, vld_s2 && !in_ch.ready, vld_s2 && $stable(phase_s2), "stalled stage moved")
	`DWES_ASSERT_IMP(a_ready_follows, clk, arst_n, out_ch.valid, in_ch.ready == out_ch.ready, "input ready not tied to output drain")

endmodule

`default_nettype wire
